// File: hdl/cloth_point_verlet_step_assert.svh
// Assertion macros for the cloth point Verlet step block
`ifndef CLOTH_POINT_VERLET_STEP_ASSERT_SVH
`define CLOTH_POINT_VERLET_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CPVS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpvs assertion failed");
`define CPVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpvs assertion failed");
`else
`define CPVS_ASSERT_SAME(label, clk, rst, ante, cons)
`define CPVS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/cpvs_pkg.sv
// Shared types and constants for the cloth point Verlet step block
package cpvs_pkg;

  localparam int NUM_POINTS = 1024;
  localparam int PTR_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int POS_W = 24;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_SET    = 2'd1,
    KIND_PIN    = 2'd2,
    KIND_UPDATE = 2'd3
  } kind_t;

  localparam logic [2:0] REG_DRAG          = 3'd0;
  localparam logic [2:0] REG_ACCEL_X       = 3'd1;
  localparam logic [2:0] REG_ACCEL_Y       = 3'd2;
  localparam logic [2:0] REG_ELASTICITY    = 3'd3;
  localparam logic [2:0] REG_CURSOR_SIZE   = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;

  localparam logic [15:0] DRAG_RST          = 16'd655;
  localparam logic [23:0] ACCEL_X_RST       = 24'd0;
  localparam logic [23:0] ACCEL_Y_RST       = 24'd250000;
  localparam logic [22:0] ELASTICITY_RST    = 23'd5120;
  localparam logic [11:0] CURSOR_SIZE_RST   = 12'd20;
  localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd1280;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd720;

  typedef struct packed {
    logic pinned;
    pos_t home_y;
    pos_t home_x;
    pos_t old_y;
    pos_t old_x;
    pos_t cur_y;
    pos_t cur_x;
  } entry_t;

endpackage

// File: hdl/cloth_point_verlet_step.sv
// Cloth point table with damped Verlet update, top level
//
// One item at a time: start is taken while busy is low, and the result word
// appears on new_x/new_y/selected/break_sticks with done high for exactly one
// cycle; the receiver cannot hold it off. A new item may be started in the done
// cycle. The path is the point memory read, then four registered multiply stages
// (acceleration times damping with the mouse offsets, then the squares and the
// first time-step product, then the second time-step product with selection and
// drag, then the damped velocity), and a final add, screen clamp and write back.
// Every kind of item takes the same path. The point memory needs no clearing
// after reset; a point must be created or set before it is updated or pinned.
`include "cloth_point_verlet_step_assert.svh"

module cloth_point_verlet_step
  import cpvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [9:0]         point_index,
  input  logic signed [23:0] x_value,
  input  logic signed [23:0] y_value,
  input  logic [15:0]        time_step,
  input  logic signed [15:0] mouse_x,
  input  logic signed [15:0] mouse_y,
  input  logic signed [15:0] mouse_prev_x,
  input  logic signed [15:0] mouse_prev_y,
  input  logic               left_button,
  input  logic               right_button,
  output logic               done,
  output logic signed [23:0] new_x,
  output logic signed [23:0] new_y,
  output logic               selected,
  output logic               break_sticks,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL1, S_MUL2, S_MUL3, S_FINISH
  } state_t;

  // round to nearest, halves upward, of p / 2^16
  function automatic logic signed [28:0] rnd16(input logic signed [44:0] p);
    logic signed [44:0] q;
    q = (p + 45'sd32768) >>> 16;
    return q[28:0];
  endfunction

  function automatic pos_t sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7fffff;
    else if (v < -26'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  function automatic logic signed [24:0] clampd(input logic signed [24:0] d,
                                                input logic [22:0] e);
    logic signed [24:0] es;
    es = signed'({2'b00, e});
    if (d > es) return es;
    else if (d < -es) return -es;
    else return d;
  endfunction

  // screen clamp of one axis: returns {old, cur}
  function automatic logic [47:0] settle(input logic signed [28:0] n, input pos_t c,
                                         input logic [11:0] bound);
    logic signed [28:0] lim;
    lim = signed'({9'd0, bound, 8'd0});
    if (n > lim) return {lim[23:0], lim[23:0]};
    else if (n < 29'sd0) return 48'd0;
    else return {c, n[23:0]};
  endfunction

  // configuration registers
  logic [15:0]        drag;
  logic signed [23:0] accel_x;
  logic signed [23:0] accel_y;
  logic [22:0]        elasticity;
  logic [11:0]        cursor_size;
  logic [11:0]        screen_width;
  logic [11:0]        screen_height;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      drag          <= DRAG_RST;
      accel_x       <= signed'(ACCEL_X_RST);
      accel_y       <= signed'(ACCEL_Y_RST);
      elasticity    <= ELASTICITY_RST;
      cursor_size   <= CURSOR_SIZE_RST;
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_DRAG:          drag          <= pwdata[15:0];
        REG_ACCEL_X:       accel_x       <= signed'(pwdata[23:0]);
        REG_ACCEL_Y:       accel_y       <= signed'(pwdata[23:0]);
        REG_ELASTICITY:    elasticity    <= pwdata[22:0];
        REG_CURSOR_SIZE:   cursor_size   <= pwdata[11:0];
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[11:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DRAG:          prdata = {16'd0, drag};
      REG_ACCEL_X:       prdata = 32'(accel_x);
      REG_ACCEL_Y:       prdata = 32'(accel_y);
      REG_ELASTICITY:    prdata = {9'd0, elasticity};
      REG_CURSOR_SIZE:   prdata = {20'd0, cursor_size};
      REG_SCREEN_WIDTH:  prdata = {20'd0, screen_width};
      REG_SCREEN_HEIGHT: prdata = {20'd0, screen_height};
      default:           prdata = 32'd0;
    endcase
  end

  // control
  state_t state;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // latched item
  kind_t              kind_q;
  logic [PTR_W-1:0]   addr_q;
  logic               idx_ok_q;
  pos_t               xv_q;
  pos_t               yv_q;
  logic [15:0]        dt_q;
  logic signed [15:0] mx_q;
  logic signed [15:0] my_q;
  logic signed [15:0] pmx_q;
  logic signed [15:0] pmy_q;
  logic               left_q;
  logic               right_q;

  // point memory
  entry_t mem [NUM_POINTS];
  entry_t rd_data;
  entry_t ent_next;
  logic   wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_q] <= ent_next;
    if (accept) rd_data <= mem[PTR_W'(point_index)];
  end

  // datapath
  logic signed [17:0] fs;
  logic signed [16:0] dts;
  logic signed [16:0] dmx;
  logic signed [16:0] dmy;

  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [24:0] dclx;
  logic signed [24:0] dcly;
  logic [19:0]        rad;
  logic signed [40:0] accf_x;
  logic signed [40:0] accf_y;

  logic [48:0]        sqx;
  logic [48:0]        sqy;
  logic [39:0]        rsq;
  logic signed [41:0] tax;
  logic signed [41:0] tay;

  logic               sel_q;
  logic               brk_q;
  pos_t               oldd_x;
  pos_t               oldd_y;
  logic signed [42:0] tbx;
  logic signed [42:0] tby;

  logic signed [42:0] vprod_x;
  logic signed [42:0] vprod_y;
  logic signed [26:0] tx;
  logic signed [26:0] ty;

  logic signed [49:0] sqx_full;
  logic signed [49:0] sqy_full;
  logic [49:0]        dist2;
  logic               sel_c;
  logic               drag_c;
  logic signed [24:0] a1x;
  logic signed [24:0] a1y;
  logic signed [25:0] a2x;
  logic signed [25:0] a2y;
  logic signed [24:0] diff_x;
  logic signed [24:0] diff_y;

  assign fs  = signed'({1'b0, 17'(17'h10000 - {1'b0, drag})});
  assign dts = signed'({1'b0, dt_q});
  assign dmx = 17'(mx_q) - 17'(pmx_q);
  assign dmy = 17'(my_q) - 17'(pmy_q);

  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign dist2    = {1'b0, sqx} + {1'b0, sqy};
  assign sel_c    = dist2 < {10'd0, rsq};
  assign drag_c   = left_q && sel_c;
  assign a1x      = 25'(rnd16(45'(accf_x)));
  assign a1y      = 25'(rnd16(45'(accf_y)));
  assign a2x      = 26'(rnd16(45'(tax)));
  assign a2y      = 26'(rnd16(45'(tay)));
  assign diff_x   = 25'(rd_data.cur_x) - 25'(oldd_x);
  assign diff_y   = 25'(rd_data.cur_y) - 25'(oldd_y);

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          kind_q   <= kind_t'(kind);
          addr_q   <= PTR_W'(point_index);
          idx_ok_q <= 32'(point_index) < 32'(NUM_POINTS);
          xv_q     <= x_value;
          yv_q     <= y_value;
          dt_q     <= time_step;
          mx_q     <= mouse_x;
          my_q     <= mouse_y;
          pmx_q    <= mouse_prev_x;
          pmy_q    <= mouse_prev_y;
          left_q   <= left_button;
          right_q  <= right_button;
        end
      end
      S_LOAD: begin
        dx     <= 25'(rd_data.cur_x) - 25'(signed'({mx_q, 8'h00}));
        dy     <= 25'(rd_data.cur_y) - 25'(signed'({my_q, 8'h00}));
        dclx   <= clampd(signed'({dmx, 8'h00}), elasticity);
        dcly   <= clampd(signed'({dmy, 8'h00}), elasticity);
        rad    <= {cursor_size, 8'h00};
        accf_x <= accel_x * fs;
        accf_y <= accel_y * fs;
      end
      S_MUL1: begin
        sqx <= sqx_full[48:0];
        sqy <= sqy_full[48:0];
        rsq <= rad * rad;
        tax <= a1x * dts;
        tay <= a1y * dts;
      end
      S_MUL2: begin
        sel_q  <= sel_c;
        brk_q  <= right_q && sel_c;
        oldd_x <= drag_c ? sat24(26'(rd_data.cur_x) - 26'(dclx)) : rd_data.old_x;
        oldd_y <= drag_c ? sat24(26'(rd_data.cur_y) - 26'(dcly)) : rd_data.old_y;
        tbx    <= a2x * dts;
        tby    <= a2y * dts;
      end
      S_MUL3: begin
        vprod_x <= diff_x * fs;
        vprod_y <= diff_y * fs;
        tx      <= 27'(rnd16(45'(tbx)));
        ty      <= 27'(rnd16(45'(tby)));
      end
      S_FINISH: ;
    endcase
  end

  // final add, screen clamp and entry update
  logic signed [25:0] vx;
  logic signed [25:0] vy;
  logic signed [28:0] nx;
  logic signed [28:0] ny;
  logic [47:0]        stx;
  logic [47:0]        sty;
  logic               res_sel;
  logic               res_brk;

  assign vx  = 26'(rnd16(45'(vprod_x)));
  assign vy  = 26'(rnd16(45'(vprod_y)));
  assign nx  = 29'(rd_data.cur_x) + 29'(vx) + 29'(tx);
  assign ny  = 29'(rd_data.cur_y) + 29'(vy) + 29'(ty);
  assign stx = settle(nx, rd_data.cur_x, screen_width);
  assign sty = settle(ny, rd_data.cur_y, screen_height);

  always_comb begin
    ent_next = rd_data;
    res_sel  = 1'b0;
    res_brk  = 1'b0;
    unique case (kind_q)
      KIND_CREATE: begin
        ent_next.cur_x  = xv_q;
        ent_next.cur_y  = yv_q;
        ent_next.old_x  = xv_q;
        ent_next.old_y  = yv_q;
        ent_next.home_x = xv_q;
        ent_next.home_y = yv_q;
        ent_next.pinned = 1'b0;
      end
      KIND_SET: begin
        ent_next.cur_x = xv_q;
        ent_next.cur_y = yv_q;
      end
      KIND_PIN: begin
        ent_next.pinned = 1'b1;
      end
      KIND_UPDATE: begin
        res_sel = sel_q;
        res_brk = brk_q;
        if (rd_data.pinned) begin
          ent_next.cur_x = rd_data.home_x;
          ent_next.cur_y = rd_data.home_y;
          ent_next.old_x = oldd_x;
          ent_next.old_y = oldd_y;
        end else begin
          ent_next.cur_x = stx[23:0];
          ent_next.old_x = stx[47:24];
          ent_next.cur_y = sty[23:0];
          ent_next.old_y = sty[47:24];
        end
      end
    endcase
  end

  assign wr_en = (state == S_FINISH) && idx_ok_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
      unique case (state)
        S_IDLE:   if (start) state <= S_LOAD;
        S_LOAD:   state <= S_MUL1;
        S_MUL1:   state <= S_MUL2;
        S_MUL2:   state <= S_MUL3;
        S_MUL3:   state <= S_FINISH;
        S_FINISH: begin
          state        <= S_IDLE;
          new_x        <= idx_ok_q ? ent_next.cur_x : '0;
          new_y        <= idx_ok_q ? ent_next.cur_y : '0;
          selected     <= idx_ok_q && res_sel;
          break_sticks <= idx_ok_q && res_brk;
        end
      endcase
    end
  end

  `CPVS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `CPVS_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `CPVS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `CPVS_ASSERT_SAME(a_flags_update, clk, rst, done && (kind_q != KIND_UPDATE), !selected && !break_sticks)

endmodule
